/* rtl/afp_pkg.sv */
package afp_pkg;

  // Field and state widths
  localparam int GAIN_W  = 17;
  localparam int STEP_W  = 17;
  localparam int PGAIN_W = 17;
  localparam int DRAIN_W = 16;
  localparam int CNT_W   = 40;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Combined gain factor, Q.30, saturated at 4.0
  localparam int FACT_W = 33;

  // Default parameter values
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  // Gain full scale (1.0 in Q1.16)
  localparam logic [GAIN_W-1:0] GAIN_FULL = GAIN_W'(65536);

  // Register reset values
  localparam logic [STEP_W-1:0]  FADE_STEP_RST = STEP_W'(1872);
  localparam logic [PGAIN_W-1:0] PGAIN_RST     = PGAIN_W'(16384);
  localparam logic [DRAIN_W-1:0] DRAIN_RST     = DRAIN_W'(6000);

  // Requested modes
  localparam logic [REQ_W-1:0] REQ_PLAY  = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_PAUSE = REQ_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_GN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_FRAMES = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_START_SILENT = CFG_IDX_W'(3);

  // Status seen after a tick
  typedef struct packed {
    logic             took;
    logic             finishing;
    logic             done;
    logic             pause_seen;
    logic [CNT_W-1:0] pause_cursor;
    logic             resume_seen;
    logic [CNT_W-1:0] resume_cursor;
    logic [CNT_W-1:0] frames_taken;
  } afp_status_t;

  // Lane stage enables
  typedef struct packed {
    logic load_smp;
    logic load_prod;
  } afp_lane_ctl_t;

endpackage

/* rtl/afp_ifs.sv */
interface afp_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic                          source_valid;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, req_type, source_valid, sample_left, sample_right,
                  input ready);
  modport sink   (input valid, req_type, source_valid, sample_left, sample_right,
                  output ready);
endinterface

interface afp_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          took_sample;
  logic                          finishing_now;
  logic                          done_flag;
  logic                          paused_valid;
  logic [39:0]                   paused_at;
  logic                          resumed_valid;
  logic [39:0]                   resumed_at;
  logic [39:0]                   frames_taken;

  modport source (output valid, out_left, out_right, took_sample, finishing_now,
                  done_flag, paused_valid, paused_at, resumed_valid, resumed_at,
                  frames_taken, input ready);
  modport sink   (input valid, out_left, out_right, took_sample, finishing_now,
                  done_flag, paused_valid, paused_at, resumed_valid, resumed_at,
                  frames_taken, output ready);
endinterface

interface afp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/audio_fade_pause_stop_controller.sv */
// Channel  Dir  Handshake        Contents
// in_ch    in   valid / ready    req_type, source_valid, sample_left, sample_right
// out_ch   out  valid / ready    scaled samples, took flag, drain state, cursors, count
// cfg_ch   in   valid / ready    index 0..3, 17-bit data; ready is always high
//
// Each frame passes these steps in order: accept, gain factor multiply,
// per-channel sample multiply, output load. The two chained multiplies are
// separate steps. A new frame is accepted as soon as the previous result
// sits in the output register.
// A stalled output holds the last stage; reset is synchronous, active low.
module audio_fade_pause_stop_controller
  import afp_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  afp_in_if.sink    in_ch,
  afp_out_if.source out_ch,
  afp_cfg_if.sink   cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_FACT, S_MUL, S_LOAD} state_t;

  state_t        state_r;
  logic          acc;
  logic          out_free;
  logic          out_load;
  logic [FACT_W-1:0] factor;
  afp_status_t   status;
  afp_lane_ctl_t lane_ctl;
  logic signed [SAMPLE_BITS-1:0] lane_res [CHANNELS];

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;
  afp_status_t                   out_status_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = (state_r == S_LOAD) && out_free;

  always_comb begin
    lane_ctl.load_smp  = acc;
    lane_ctl.load_prod = (state_r == S_MUL);
  end

  // Frame state and gain factor
  afp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_ch.valid),
    .cfg_idx      (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .acc          (acc),
    .req_type     (in_ch.req_type),
    .source_valid (in_ch.source_valid),
    .fact_en      (state_r == S_FACT),
    .factor       (factor),
    .status       (status)
  );

  // One scaling lane per channel
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic signed [SAMPLE_BITS-1:0] lane_smp;
    if (i == 0) begin : g_left
      assign lane_smp = in_ch.sample_left;
    end else begin : g_right
      assign lane_smp = in_ch.sample_right;
    end
    afp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .sample (lane_smp),
      .factor (factor),
      .result (lane_res[i])
    );
  end

  // Sequencer and output register: merge lanes with status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            state_r <= S_FACT;
          end
        end
        S_FACT: state_r <= S_MUL;
        S_MUL:  state_r <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status;
            out_left_r   <= status.took ? lane_res[0] : '0;
            if (CHANNELS > 1) begin
              out_right_r <= status.took ? lane_res[CHANNELS-1] : '0;
            end else begin
              out_right_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_left      = out_left_r;
  assign out_ch.out_right     = out_right_r;
  assign out_ch.took_sample   = out_status_r.took;
  assign out_ch.finishing_now = out_status_r.finishing;
  assign out_ch.done_flag     = out_status_r.done;
  assign out_ch.paused_valid  = out_status_r.pause_seen;
  assign out_ch.paused_at     = out_status_r.pause_cursor;
  assign out_ch.resumed_valid = out_status_r.resume_seen;
  assign out_ch.resumed_at    = out_status_r.resume_cursor;
  assign out_ch.frames_taken  = out_status_r.frames_taken;

endmodule

/* rtl/afp_ctrl.sv */
module afp_ctrl
  import afp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  logic [REQ_W-1:0]      req_type,
  input  logic                  source_valid,
  input  logic                  fact_en,
  output logic [FACT_W-1:0]     factor,
  output afp_status_t           status
);

  localparam logic [DRAIN_W-1:0] TAIL_MAX = '1;
  localparam logic [2*GAIN_W-1:0] FACT_MAX = (2*GAIN_W)'(64'd1 << 32);

  logic [STEP_W-1:0]  fade_step_r;
  logic [PGAIN_W-1:0] pgain_r;
  logic [DRAIN_W-1:0] drain_r;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [GAIN_W-1:0]  g_r, g_nxt;
  logic [DRAIN_W-1:0] tail_r, tail_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic               took_r, took_nxt;
  logic [CNT_W-1:0]   frames_r, frames_nxt;
  logic [CNT_W-1:0]   pcur_r, pcur_nxt;
  logic               pseen_r, pseen_nxt;
  logic [CNT_W-1:0]   rcur_r, rcur_nxt;
  logic               rseen_r, rseen_nxt;
  logic [FACT_W-1:0]  factor_r;

  logic               play, pause, tail_add, tail_one;
  logic [GAIN_W:0]    gain_sum;
  logic [DRAIN_W-1:0] tail_sum;
  logic [2*GAIN_W-1:0] fact_full;

  // Per-tick state update
  always_comb begin
    play       = (req_type == REQ_PLAY);
    pause      = (req_type == REQ_PAUSE);
    gain_sum   = {1'b0, gain_r} + {1'b0, fade_step_r};
    gain_nxt   = gain_r;
    g_nxt      = g_r;
    fin_nxt    = fin_r;
    done_nxt   = done_r;
    took_nxt   = 1'b0;
    frames_nxt = frames_r;
    pcur_nxt   = pcur_r;
    pseen_nxt  = pseen_r;
    rcur_nxt   = rcur_r;
    rseen_nxt  = rseen_r;
    tail_add   = 1'b0;
    tail_one   = 1'b0;
    if (done_r) begin
      // silent, frozen
    end else if (fin_r) begin
      tail_add = 1'b1;
      tail_one = 1'b1;
    end else if (!play && gain_r == '0) begin
      if (pause) begin
        if (!pseen_r) begin
          pcur_nxt  = frames_r;
          pseen_nxt = 1'b1;
        end
      end else begin
        fin_nxt  = 1'b1;
        tail_add = 1'b1;
        tail_one = 1'b1;
      end
    end else begin
      if (play && gain_r == '0 && pseen_r && !rseen_r) begin
        rcur_nxt  = frames_r;
        rseen_nxt = 1'b1;
      end
      if (!source_valid) begin
        fin_nxt  = 1'b1;
        tail_add = 1'b1;
        tail_one = 1'b1;
      end else begin
        if (play) begin
          gain_nxt = (gain_sum > {1'b0, GAIN_FULL}) ? GAIN_FULL : gain_sum[GAIN_W-1:0];
          g_nxt    = gain_nxt;
        end else begin
          g_nxt    = gain_r;
          gain_nxt = (fade_step_r >= gain_r) ? '0 : gain_r - fade_step_r;
        end
        took_nxt   = 1'b1;
        frames_nxt = frames_r + CNT_W'(1);
        if (pause && gain_nxt == '0 && !pseen_r) begin
          pcur_nxt  = frames_nxt;
          pseen_nxt = 1'b1;
        end
        if (!play && !pause && gain_nxt == '0) begin
          fin_nxt  = 1'b1;
          tail_add = 1'b1;
        end
      end
    end
    // drain counter, saturating
    tail_sum = (tail_one && tail_r != TAIL_MAX) ? tail_r + DRAIN_W'(1) : tail_r;
    tail_nxt = tail_add ? tail_sum : tail_r;
    if (tail_add && tail_sum >= drain_r) begin
      done_nxt = 1'b1;
    end
  end

  // Combined gain, saturated at 4.0
  always_comb begin
    fact_full = (2*GAIN_W)'(g_r) * (2*GAIN_W)'(pgain_r);
    if (fact_full > FACT_MAX) begin
      fact_full = FACT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r <= FADE_STEP_RST;
      pgain_r     <= PGAIN_RST;
      drain_r     <= DRAIN_RST;
      gain_r      <= GAIN_FULL;
      tail_r      <= '0;
      fin_r       <= 1'b0;
      done_r      <= 1'b0;
      took_r      <= 1'b0;
      frames_r    <= '0;
      pcur_r      <= '0;
      pseen_r     <= 1'b0;
      rcur_r      <= '0;
      rseen_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_FADE_STEP:    fade_step_r <= cfg_data[STEP_W-1:0];
          REG_PLAYBACK_GN:  pgain_r     <= cfg_data[PGAIN_W-1:0];
          REG_DRAIN_FRAMES: drain_r     <= cfg_data[DRAIN_W-1:0];
          REG_START_SILENT: gain_r      <= cfg_data[0] ? '0 : GAIN_FULL;
          default: ;
        endcase
      end
      if (acc) begin
        gain_r   <= gain_nxt;
        tail_r   <= tail_nxt;
        fin_r    <= fin_nxt;
        done_r   <= done_nxt;
        took_r   <= took_nxt;
        frames_r <= frames_nxt;
        pcur_r   <= pcur_nxt;
        pseen_r  <= pseen_nxt;
        rcur_r   <= rcur_nxt;
        rseen_r  <= rseen_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      g_r <= g_nxt;
    end
    if (fact_en) begin
      factor_r <= fact_full[FACT_W-1:0];
    end
  end

  assign factor = factor_r;

  always_comb begin
    status.took          = took_r;
    status.finishing     = fin_r;
    status.done          = done_r;
    status.pause_seen    = pseen_r;
    status.pause_cursor  = pcur_r;
    status.resume_seen   = rseen_r;
    status.resume_cursor = rcur_r;
    status.frames_taken  = frames_r;
  end

endmodule

/* rtl/afp_lane.sv */
module afp_lane
  import afp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  afp_lane_ctl_t                 ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [FACT_W-1:0]             factor,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_W = SAMPLE_BITS + FACT_W;
  localparam int RND_W  = PROD_W - 30;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1 << 29);
  localparam logic [RND_W-1:0]  POS_MAX = RND_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [RND_W-1:0]  NEG_MAX = RND_W'(64'd1 << (SAMPLE_BITS - 1));

  logic                   neg_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [PROD_W-1:0]      prod_r;
  logic [PROD_W-1:0]      rsum;
  logic [RND_W-1:0]       rval;
  logic [SAMPLE_BITS-1:0] rsat;

  // Sign and magnitude, then scale
  always_ff @(posedge clk) begin
    if (ctl.load_smp) begin
      neg_r <= sample[SAMPLE_BITS-1];
      mag_r <= sample[SAMPLE_BITS-1] ? -sample : sample;
    end
    if (ctl.load_prod) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(factor);
    end
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    rsum = prod_r + HALF;
    rval = rsum[PROD_W-1:30];
    if (neg_r) begin
      rsat = (rval > NEG_MAX) ? NEG_MAX[SAMPLE_BITS-1:0] : rval[SAMPLE_BITS-1:0];
    end else begin
      rsat = (rval > POS_MAX) ? POS_MAX[SAMPLE_BITS-1:0] : rval[SAMPLE_BITS-1:0];
    end
    result = neg_r ? -rsat : rsat;
  end

endmodule

/* tb/sv/afp_tb_pkg.sv */
package afp_tb_pkg;
  import afp_pkg::*;

  localparam int SMP_W = SAMPLE_BITS_DEF;

  // Modes the RTL package leaves unnamed
  localparam logic [REQ_W-1:0] REQ_STOP    = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = REQ_W'(3);

  localparam logic [SMP_W-1:0]      SMP_MAX      = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0]      SMP_MIN      = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0] CFG_DATA_MAX = '1;

  localparam bit [63:0] FACTOR_MAX  = 64'd1 << 32;  // 4.0 in Q.30
  localparam bit [63:0] FACTOR_HALF = 64'd1 << 29;  // rounding offset
  localparam bit [63:0] SMP_SIGN    = 64'd1 << (SMP_W - 1);
  localparam int        MAX_REPORTS = 100;

  typedef struct {
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    afp_status_t      st;
  } frame_result_t;

  class fade_tracker;
    // register copies
    bit [STEP_W-1:0]  step;
    bit [PGAIN_W-1:0] pgain;
    bit [DRAIN_W-1:0] drain;
    // player state; gain has one spare bit for the unclamped sum
    bit [GAIN_W:0]    gain;
    bit [DRAIN_W-1:0] tail;
    bit               finishing;
    bit               done;
    bit               pause_seen;
    bit               resume_seen;
    bit [CNT_W-1:0]   taken;
    bit [CNT_W-1:0]   pause_at;
    bit [CNT_W-1:0]   resume_at;
    frame_result_t    expected_frames[$];
    int               mismatches;
    int               frames_checked;
    int               silent_frames;

    function void reset_state();
      step           = FADE_STEP_RST;
      pgain          = PGAIN_RST;
      drain          = DRAIN_RST;
      gain           = GAIN_FULL;
      tail           = '0;
      finishing      = 1'b0;
      done           = 1'b0;
      pause_seen     = 1'b0;
      resume_seen    = 1'b0;
      taken          = '0;
      pause_at       = '0;
      resume_at      = '0;
      mismatches     = 0;
      frames_checked = 0;
      silent_frames  = 0;
      expected_frames.delete();
    endfunction

    // start_silent also reloads the gain
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_FADE_STEP:    step  = value;
        REG_PLAYBACK_GN:  pgain = value;
        REG_DRAIN_FRAMES: drain = value[DRAIN_W-1:0];
        REG_START_SILENT: begin
          if (value[0]) gain = '0;
          else gain = GAIN_FULL;
        end
      endcase
    endfunction

    // sample * gain * playback gain / 2^30, ties away from zero, saturated
    function bit [SMP_W-1:0] scale_frame(bit [SMP_W-1:0] raw, bit [GAIN_W:0] g);
      bit [SMP_W-1:0] mag;
      bit [63:0]      factor;
      bit [63:0]      r;
      mag    = raw[SMP_W-1] ? -raw : raw;
      factor = 64'(g) * 64'(pgain);
      if (factor > FACTOR_MAX) factor = FACTOR_MAX;
      r = (64'(mag) * factor + FACTOR_HALF) >> 30;
      if (raw[SMP_W-1]) begin
        if (r > SMP_SIGN) r = SMP_SIGN;
        return SMP_W'(64'd0 - r);
      end
      if (r > SMP_SIGN - 1) r = SMP_SIGN - 1;
      return SMP_W'(r);
    endfunction

    // drain counter saturates; done once it reaches drain
    function void add_tail(int unsigned n);
      bit [DRAIN_W:0] sum;
      if (!finishing) return;
      sum = tail + n;
      if (sum > {DRAIN_W{1'b1}}) tail = {DRAIN_W{1'b1}};
      else tail = sum[DRAIN_W-1:0];
      if (tail >= drain) done = 1'b1;
    endfunction

    // advance the player by one accepted frame and queue its result
    function void note_frame(logic [REQ_W-1:0] req, logic src,
                             logic [SMP_W-1:0] left, logic [SMP_W-1:0] right);
      frame_result_t e;
      bit            play;
      bit            pause;
      bit [GAIN_W:0] g;
      play         = (req == REQ_PLAY);
      pause        = (req == REQ_PAUSE);
      e.left       = '0;
      e.right      = '0;
      e.st.took    = 1'b0;
      if (done) begin
        // terminal: silent, nothing moves
      end else if (finishing) begin
        add_tail(1);
      end else if (!play && gain == 0) begin
        if (pause) begin
          if (!pause_seen) begin
            pause_at   = taken;
            pause_seen = 1'b1;
          end
        end else begin
          finishing = 1'b1;
          add_tail(1);
        end
      end else begin
        if (play && gain == 0 && pause_seen && !resume_seen) begin
          resume_at   = taken;
          resume_seen = 1'b1;
        end
        if (!src) begin
          finishing = 1'b1;
          add_tail(1);
        end else begin
          if (play) begin
            gain = gain + step;
            if (gain > GAIN_FULL) gain = GAIN_FULL;
            g = gain;
          end else begin
            g    = gain;
            gain = (step >= gain) ? '0 : gain - step;
          end
          e.left    = scale_frame(left, g);
          e.right   = scale_frame(right, g);
          e.st.took = 1'b1;
          taken     = taken + 1'b1;
          if (pause && gain == 0 && !pause_seen) begin
            pause_at   = taken;
            pause_seen = 1'b1;
          end
          // stop fade just hit zero: drain starts with no tail added
          if (!play && !pause && gain == 0) begin
            finishing = 1'b1;
            add_tail(0);
          end
        end
      end
      if (!e.st.took) silent_frames++;
      e.st.finishing     = finishing;
      e.st.done          = done;
      e.st.pause_seen    = pause_seen;
      e.st.pause_cursor  = pause_at;
      e.st.resume_seen   = resume_seen;
      e.st.resume_cursor = resume_at;
      e.st.frames_taken  = taken;
      expected_frames.push_back(e);
    endfunction

    function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_frame(frame_result_t act);
      frame_result_t e;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no frame outstanding, expected none, actual taken=%0h",
                   $time, act.st.frames_taken);
        return;
      end
      e = expected_frames.pop_front();
      frames_checked++;
      cmp_field("out_left", e.left, act.left);
      cmp_field("out_right", e.right, act.right);
      cmp_field("took_sample", e.st.took, act.st.took);
      cmp_field("finishing_now", e.st.finishing, act.st.finishing);
      cmp_field("done_flag", e.st.done, act.st.done);
      cmp_field("paused_valid", e.st.pause_seen, act.st.pause_seen);
      cmp_field("paused_at", e.st.pause_cursor, act.st.pause_cursor);
      cmp_field("resumed_valid", e.st.resume_seen, act.st.resume_seen);
      cmp_field("resumed_at", e.st.resume_cursor, act.st.resume_cursor);
      cmp_field("frames_taken", e.st.frames_taken, act.st.frames_taken);
    endfunction
  endclass

endpackage

/* tb/sv/audio_fade_pause_stop_controller_tb.sv */
module audio_fade_pause_stop_controller_tb;
  import afp_pkg::*;
  import afp_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_FRAMES  = 210;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RANDOM, STALL_HEAVY} stall_mode_t;
  typedef enum int {END_SOURCE, END_STOP_FADE, END_STOP_SILENT} end_path_t;

  logic clk;
  logic rst_n;

  afp_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_if ();
  afp_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) out_if ();
  afp_cfg_if cfg_if ();

  fade_tracker tracker = new;
  int          burst_left;
  int          cycle_count = 0;

  audio_fade_pause_stop_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // check every result transaction against the oldest prediction
  always @(posedge clk) begin : result_monitor
    frame_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.left               = out_if.out_left;
      got.right              = out_if.out_right;
      got.st.took            = out_if.took_sample;
      got.st.finishing       = out_if.finishing_now;
      got.st.done            = out_if.done_flag;
      got.st.pause_seen      = out_if.paused_valid;
      got.st.pause_cursor    = out_if.paused_at;
      got.st.resume_seen     = out_if.resumed_valid;
      got.st.resume_cursor   = out_if.resumed_at;
      got.st.frames_taken    = out_if.frames_taken;
      tracker.check_frame(got);
    end
  end

  // receiver backpressure: rotating stall patterns plus one long hold-off
  initial begin : result_sink
    stall_mode_t mode;
    int          mode_left;
    int          tick;
    int          hold_left;
    bit          hold_done;
    mode         = STALL_NONE;
    mode_left    = 0;
    tick         = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else if (!hold_done && tracker.frames_checked >= HOLD_AFTER) begin
        hold_done    = 1'b1;
        hold_left    = LONG_HOLD - 1;
        out_if.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(STALL_HEAVY, STALL_NONE));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          STALL_NONE:   out_if.ready = 1'b1;
          STALL_SPARSE: out_if.ready = (tick % 4) != 0;
          STALL_RANDOM: out_if.ready = 1'($urandom_range(1, 0));
          default:      out_if.ready = (tick % 5) == 0;
        endcase
      end
    end
  end

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3:       return '1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // one frame transaction; bursts of random length with random gaps between
  task automatic send_frame(input logic [REQ_W-1:0] req, input logic src,
                            input logic [SMP_W-1:0] left, input logic [SMP_W-1:0] right);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_if.valid        = 1'b1;
    in_if.req_type     = req;
    in_if.source_valid = src;
    in_if.sample_left  = left;
    in_if.sample_right = right;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.note_frame(req, src, left, right);
    burst_left--;
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin : stimulus
    logic [REQ_W-1:0]      req;
    logic [REQ_W-1:0]      run_req;
    logic [CFG_DATA_W-1:0] step_v;
    logic [CFG_DATA_W-1:0] pgain_v;
    logic [CFG_DATA_W-1:0] drain_v;
    end_path_t             end_path;
    int                    run_len;
    int                    sent;
    int                    pick;
    int                    post;

    // known levels from time zero
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_PLAY;
    in_if.source_valid = 1'b0;
    in_if.sample_left  = '0;
    in_if.sample_right = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_FADE_STEP;
    cfg_if.data        = '0;
    burst_left         = 0;
    tracker.reset_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: sample extremes at unity gain, every mode while fading
    send_frame(REQ_PLAY, 1'b1, SMP_MAX, SMP_MIN);
    send_frame(REQ_PLAY, 1'b1, '0, '1);
    send_frame(REQ_PLAY, 1'b1, SMP_W'(1), rand_sample());
    send_frame(REQ_PAUSE, 1'b1, SMP_MIN, SMP_MAX);
    send_frame(REQ_STOP, 1'b1, rand_sample(), rand_sample());
    send_frame(REQ_UNKNOWN, 1'b1, rand_sample(), rand_sample());

    // zero step holds the gain; oversized playback gain saturates the factor
    settle();
    write_reg(REG_FADE_STEP, '0);
    write_reg(REG_PLAYBACK_GN, CFG_DATA_MAX);
    send_frame(REQ_PLAY, 1'b1, SMP_MAX, SMP_MIN);
    send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    settle();
    write_reg(REG_PLAYBACK_GN, '0);
    send_frame(REQ_PLAY, 1'b1, SMP_MAX, SMP_MIN);

    // fade in from silence with no pause yet, then the pause and resume cursors
    settle();
    write_reg(REG_PLAYBACK_GN, CFG_DATA_W'(GAIN_FULL));
    write_reg(REG_START_SILENT, CFG_DATA_W'(1));
    write_reg(REG_FADE_STEP, CFG_DATA_W'(GAIN_FULL));
    send_frame(REQ_PLAY, 1'b1, rand_sample(), rand_sample());
    if ($urandom_range(1)) begin
      // pause fade lands on zero
      send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    end else begin
      // pause finds the gain already at zero
      settle();
      write_reg(REG_START_SILENT, CFG_DATA_W'(1));
      send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    end
    send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    send_frame(REQ_PLAY, 1'b1, SMP_MAX, SMP_MIN);

    // steps past full scale clamp both ways
    settle();
    write_reg(REG_FADE_STEP, CFG_DATA_MAX);
    send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    send_frame(REQ_PAUSE, 1'b1, rand_sample(), rand_sample());
    send_frame(REQ_PLAY, 1'b1, rand_sample(), rand_sample());

    // random phases: runs of one mode so fades complete, with some noise;
    // stop and unknown modes are held back whenever they would end playback
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      drain_v = CFG_DATA_W'($urandom_range(16'hFFFF));
      case (ph)
        0: begin
          step_v  = CFG_DATA_W'(1);
          pgain_v = CFG_DATA_MAX;
          drain_v = CFG_DATA_W'(16'hFFFF);
        end
        1: begin
          step_v  = CFG_DATA_MAX;
          pgain_v = '0;
          drain_v = '0;
        end
        2: begin
          step_v  = CFG_DATA_W'(GAIN_FULL);
          pgain_v = CFG_DATA_W'(GAIN_FULL);
        end
        default: begin
          pick    = $urandom_range(5);
          step_v  = (pick == 0) ? '0 :
                    (pick < 3)  ? CFG_DATA_W'($urandom_range(256, 4096)) :
                                  CFG_DATA_W'($urandom_range(4096, 65536));
          pgain_v = CFG_DATA_W'($urandom_range(CFG_DATA_MAX));
        end
      endcase
      write_reg(REG_FADE_STEP, step_v);
      write_reg(REG_PLAYBACK_GN, pgain_v);
      write_reg(REG_DRAIN_FRAMES, drain_v);
      write_reg(REG_START_SILENT, CFG_DATA_W'($urandom_range(1)));
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        pick    = $urandom_range(99);
        run_req = (pick < 45) ? REQ_PLAY : (pick < 80) ? REQ_PAUSE :
                  (pick < 90) ? REQ_STOP : REQ_UNKNOWN;
        run_len = $urandom_range(1, ($urandom_range(3) == 0) ? 90 : 30);
        repeat (run_len) begin
          req = run_req;
          if ($urandom_range(15) == 0) req = REQ_W'($urandom_range(3));
          if ((req == REQ_STOP || req == REQ_UNKNOWN) && tracker.step >= tracker.gain)
            req = REQ_PAUSE;
          send_frame(req, 1'b1, rand_sample(), rand_sample());
          sent++;
        end
      end
    end

    // end of playback: short drain, then frames after done
    settle();
    write_reg(REG_FADE_STEP, CFG_DATA_W'($urandom_range(4096, 65536)));
    write_reg(REG_DRAIN_FRAMES,
              ($urandom_range(3) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 30)));
    write_reg(REG_START_SILENT, CFG_DATA_W'($urandom_range(1)));
    end_path = end_path_t'($urandom_range(END_STOP_SILENT, END_SOURCE));
    while (!tracker.finishing) begin
      req = $urandom_range(1) ? REQ_STOP : REQ_UNKNOWN;
      case (end_path)
        END_SOURCE:    send_frame(REQ_PLAY, 1'b0, rand_sample(), rand_sample());
        END_STOP_FADE: send_frame(req, 1'b1, rand_sample(), rand_sample());
        default: begin
          if (tracker.gain != 0) req = REQ_PAUSE;
          send_frame(req, 1'b1, rand_sample(), rand_sample());
        end
      endcase
    end
    post = tracker.drain + $urandom_range(20, 40);
    repeat (post)
      send_frame(REQ_W'($urandom_range(3)), 1'($urandom_range(1)), rand_sample(),
                 rand_sample());

    // drain the pipeline
    @(negedge clk);
    in_if.valid = 1'b0;
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result transactions over %0d register phases: %0d frames taken, %0d silent.",
             tracker.frames_checked, PHASES + 4, tracker.taken, tracker.silent_frames);
    $display("Pause cursor %0d at %0d, resume cursor %0d at %0d, end path %s, done=%0d.",
             tracker.pause_seen, tracker.pause_at, tracker.resume_seen, tracker.resume_at,
             end_path.name(), tracker.done);
    if (tracker.mismatches == 0 && tracker.expected_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
